[src/lnsp_pkg.sv]
// ----------------------------------------------------------------------------
// lnsp_pkg
// Shared types and codes for the looping note sequence player: beat layouts,
// table entry layout and the command/status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lnsp_pkg;

  localparam int TIME_W = 48;

  // action codes
  localparam logic ACT_WRITE   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // entry kinds
  localparam logic KIND_NOTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic                action;
    logic [7:0]          entry_index;
    logic [31:0]         entry_start;
    logic                entry_kind;
    logic signed [15:0]  entry_pitch;
    logic [31:0]         entry_length;
    logic [TIME_W-1:0]   now_time;
    logic                model_changed;
    logic                access_denied;
  } in_t;

  typedef struct packed {
    logic                gate_written;
    logic                gate_level;
    logic                pitch_written;
    logic signed [15:0]  pitch_value;
    logic                lock_failed;
    logic                last;
  } out_t;

  typedef struct packed {
    logic         kind;
    logic [31:0]  start;
    logic [15:0]  pitch;
    logic [31:0]  length;
  } entry_t;

  typedef struct packed {
    logic wr_en;      // write input beat into table
    logic latch_now;  // capture play time
    logic restart;    // clear cursor, loop base, held note
    logic rd;         // read table at cursor
    logic cmp;        // evaluate due and release compares
    logic emit_off;   // gate-off result
    logic emit_on;    // gate-on result, take the note
    logic emit_fail;  // refused advance result
    logic wrap_zero;  // empty loop: cursor back to slot 0
    logic wrap_loop;  // end entry: advance loop base, cursor to slot 0
    logic flush;      // send held result as the final one
  } ctrl_cmd_t;

  typedef struct packed {
    logic rel_hit;
    logic due_le;
    logic kind;
    logic st_zero;
    logic hold_valid;
    logic can_emit;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/looping_note_sequence_player.sv]
// ----------------------------------------------------------------------------
// looping_note_sequence_player
// Plays a looping table of note events against an advancing musical time.
// ----------------------------------------------------------------------------
// An advance beat runs catch-up steps (table read, time compare, release
// check, due check, step count), at most 2*MAX_RESULTS steps, and waits
// whenever the output side stalls; each step reads one entry through the
// single read port of the event table. A new beat is taken only in idle.
// Results leave through a one-deep held stage and an output register, so
// the final result of a beat is marked last once the walk ends. Table
// slots come up undefined and need no clearing pass.
`default_nettype none

module looping_note_sequence_player #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_RESULTS = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire lnsp_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output lnsp_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic           cfg_data
);

  lnsp_pkg::ctrl_cmd_t cmd;
  lnsp_pkg::dp_stat_t  stat;

  lnsp_ctrl #(
    .MAX_RESULTS (MAX_RESULTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  lnsp_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/lnsp_dp.sv]
// ----------------------------------------------------------------------------
// lnsp_dp
// Datapath: event table memory, play position registers, time compares,
// one held result plus the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsp_dp #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lnsp_pkg::in_t       in_data,
  input  wire lnsp_pkg::ctrl_cmd_t cmd,
  output lnsp_pkg::dp_stat_t       stat,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lnsp_pkg::out_t           out_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int TW = lnsp_pkg::TIME_W;

  lnsp_pkg::entry_t mem [TABLE_DEPTH];
  lnsp_pkg::entry_t mem_q;

  logic [AW+7:0]  wr_wide;
  logic           wr_ok;
  logic [AW-1:0]  cursor;
  logic [TW-1:0]  loop_base;
  logic [TW-1:0]  release_time;
  logic           release_pending;
  logic [TW-1:0]  now_r;
  logic [TW-1:0]  due_r;
  logic           due_le_r;
  logic           rel_hit_r;
  logic [TW:0]    due_sum;
  logic [TW:0]    rel_sum;
  logic [TW-1:0]  rel_sat;
  logic           hold_valid;
  lnsp_pkg::out_t hold;
  lnsp_pkg::out_t hold_out;
  lnsp_pkg::out_t new_res;
  logic           emit;
  logic           out_free;

  assign wr_wide = (AW+8)'(in_data.entry_index);
  assign wr_ok   = wr_wide < (AW+8)'(TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[wr_wide[AW-1:0]] <= '{kind:   in_data.entry_kind,
                                start:  in_data.entry_start,
                                pitch:  in_data.entry_pitch,
                                length: in_data.entry_length};
    end
    if (cmd.rd) begin
      mem_q <= mem[cursor];
    end
  end

  // due sum keeps its carry for the due compare; the stored due time and loop base drop it
  assign due_sum = {1'b0, loop_base} + (TW+1)'(mem_q.start);
  assign rel_sum = {1'b0, due_r} + (TW+1)'(mem_q.length);
  assign rel_sat = rel_sum[TW] ? {TW{1'b1}} : rel_sum[TW-1:0];

  // compare results and play time
  always_ff @(posedge clk) begin
    if (cmd.latch_now) begin
      now_r <= in_data.now_time;
    end
    if (cmd.cmp) begin
      due_r     <= due_sum[TW-1:0];
      due_le_r  <= due_sum <= {1'b0, now_r};
      rel_hit_r <= release_pending && (release_time <= now_r);
    end
    if (cmd.emit_on) begin
      release_time <= rel_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor          <= '0;
      loop_base       <= '0;
      release_pending <= 1'b0;
    end else begin
      if (cmd.restart) begin
        cursor          <= '0;
        loop_base       <= '0;
        release_pending <= 1'b0;
      end
      if (cmd.emit_off) begin
        release_pending <= 1'b0;
      end
      if (cmd.emit_on) begin
        release_pending <= 1'b1;
        cursor <= (cursor == AW'(TABLE_DEPTH - 1)) ? '0 : cursor + 1'b1;
      end
      if (cmd.wrap_zero) begin
        cursor <= '0;
      end
      if (cmd.wrap_loop) begin
        cursor    <= '0;
        loop_base <= due_r;
      end
    end
  end

  always_comb begin
    new_res = '0;
    if (cmd.emit_off) begin
      new_res.gate_written = 1'b1;
    end
    if (cmd.emit_on) begin
      new_res.gate_written  = 1'b1;
      new_res.gate_level    = 1'b1;
      new_res.pitch_written = 1'b1;
      new_res.pitch_value   = mem_q.pitch;
    end
    if (cmd.emit_fail) begin
      new_res.lock_failed = 1'b1;
    end
  end

  assign emit     = cmd.emit_off | cmd.emit_on | cmd.emit_fail;
  assign out_free = !out_valid || out_ready;

  // a new result pushes the held one out; the held one goes out last on flush
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if ((emit && hold_valid) || cmd.flush) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    hold_out      = hold;
    hold_out.last = cmd.flush;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hold <= new_res;
    end
    if ((emit && hold_valid) || cmd.flush) begin
      out_data <= hold_out;
    end
  end

  assign stat.rel_hit    = rel_hit_r;
  assign stat.due_le     = due_le_r;
  assign stat.kind       = mem_q.kind;
  assign stat.st_zero    = (mem_q.start == '0);
  assign stat.hold_valid = hold_valid;
  assign stat.can_emit   = !hold_valid || out_free;
  assign stat.out_free   = out_free;

endmodule

`default_nettype wire

[src/lnsp_ctrl.sv]
// ----------------------------------------------------------------------------
// lnsp_ctrl
// Controller: takes input beats, runs the catch-up sequence one table entry
// per step, counts results and steps, holds the playing and restart flags.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsp_ctrl #(
  parameter int MAX_RESULTS = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lnsp_pkg::in_t       in_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_data,
  input  wire lnsp_pkg::dp_stat_t  stat,
  output lnsp_pkg::ctrl_cmd_t      cmd
);

  localparam int NW = $clog2(MAX_RESULTS + 1);
  localparam int GW = $clog2(2 * MAX_RESULTS + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RD   = 7'b0000010,
    S_CMP  = 7'b0000100,
    S_REL  = 7'b0001000,
    S_DUE  = 7'b0010000,
    S_NEXT = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [NW-1:0] n, n_next;
  logic [GW-1:0] guard, guard_next;
  logic          did, did_next;
  logic          playing;
  logic          restart_pending, restart_pending_next;
  logic          accept;
  logic          n_full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign n_full   = (n == NW'(MAX_RESULTS));

  always_comb begin
    state_next           = state;
    n_next               = n;
    guard_next           = guard;
    did_next             = did;
    restart_pending_next = restart_pending;
    cmd                  = '0;
    cmd.latch_now        = accept;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_data.action == lnsp_pkg::ACT_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            if (in_data.model_changed) begin
              restart_pending_next = 1'b1;
            end
            if (playing) begin
              if (in_data.access_denied) begin
                restart_pending_next = 1'b1;
                cmd.emit_fail        = 1'b1;
                state_next           = S_FIN;
              end else begin
                if (restart_pending || in_data.model_changed) begin
                  cmd.restart          = 1'b1;
                  restart_pending_next = 1'b0;
                end
                n_next     = '0;
                guard_next = '0;
                state_next = S_RD;
              end
            end
          end
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp    = 1'b1;
        did_next   = 1'b0;
        state_next = S_REL;
      end
      S_REL: begin
        if (!stat.rel_hit) begin
          state_next = S_DUE;
        end else if (n_full) begin
          state_next = S_FIN;
        end else if (stat.can_emit) begin
          cmd.emit_off = 1'b1;
          n_next       = n + 1'b1;
          did_next     = 1'b1;
          state_next   = S_DUE;
        end
      end
      S_DUE: begin
        if (!stat.due_le) begin
          state_next = did ? S_NEXT : S_FIN;
        end else if (stat.kind == lnsp_pkg::KIND_NOTE) begin
          if (n_full) begin
            state_next = S_FIN;
          end else if (stat.can_emit) begin
            cmd.emit_on = 1'b1;
            n_next      = n + 1'b1;
            state_next  = S_NEXT;
          end
        end else if (stat.st_zero) begin
          // empty loop: park at slot 0 and stop for this beat
          cmd.wrap_zero = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.wrap_loop = 1'b1;
          state_next    = S_NEXT;
        end
      end
      S_NEXT: begin
        guard_next = guard + 1'b1;
        state_next = (guard == GW'(2 * MAX_RESULTS - 1)) ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      n               <= '0;
      guard           <= '0;
      did             <= 1'b0;
      playing         <= 1'b0;
      restart_pending <= 1'b1;
    end else begin
      state           <= state_next;
      n               <= n_next;
      guard           <= guard_next;
      did             <= did_next;
      restart_pending <= restart_pending_next;
      if (cfg_we) begin
        playing <= cfg_data;
      end
    end
  end

endmodule

`default_nettype wire

[src/lnsp_checker.sv]
// ----------------------------------------------------------------------------
// lnsp_checker
// Port-level checks on the result stream of the note sequence player.
// ----------------------------------------------------------------------------
`default_nettype none

module lnsp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire lnsp_pkg::out_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // a refused advance is a lone final result
  a_fail_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.lock_failed |->
      out_data.last && !out_data.gate_written && !out_data.pitch_written)
    else $error("lock failure result malformed");

  // pitch only moves with a gate-on
  a_pitch_gate: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pitch_written |->
      out_data.gate_written && out_data.gate_level && !out_data.lock_failed)
    else $error("pitch written without gate-on");

endmodule

bind looping_note_sequence_player lnsp_checker u_lnsp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
